// ===== rtl/tcd_pkg.sv =====
// ---------------------------------------------------------------------------
// tcd_pkg
// Shared types and constants of the trilinear charge deposit core.
// ---------------------------------------------------------------------------
`default_nettype none
package tcd_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y      = 2'd2;

  localparam int SCALE_W = 32;
  localparam int CELLS_W = 6;
  localparam int NODE_W  = 15;
  localparam int OFS_W   = 17;
  localparam int CHG_W   = 24;
  localparam int SUM_W   = 48;

  // Corner addresses before the range check; wide enough for the largest node index plus corner offsets.
  localparam int ADDR_W  = 21;
  localparam int WGT_W   = 42;

  typedef struct packed {
    logic                     rd;
    logic [ADDR_W-1:0]        addr;
    logic signed [WGT_W-1:0]  weight;
  } op_t;

endpackage
`default_nettype wire

// ===== rtl/tcd_ram.sv =====
// ---------------------------------------------------------------------------
// tcd_ram
// Generic memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none
module tcd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tcd_fifo.sv =====
// ---------------------------------------------------------------------------
// tcd_fifo
// Short request queue between the weight front end and the accumulator.
// ---------------------------------------------------------------------------
`default_nettype none
module tcd_fifo
  import tcd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire op_t  push_op,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output op_t       head
);

  op_t        q_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] count_r;
  logic       do_push, do_pop;

  assign full    = (count_r == 3'd4);
  assign empty   = (count_r == 3'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_op;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 2'd1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 2'd1;
      count_r <= count_r + {2'd0, do_push} - {2'd0, do_pop};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tcd_front.sv =====
// ---------------------------------------------------------------------------
// tcd_front
// Accepts items, forms the eight trilinear weights and corner addresses of a
// deposit, and queues one request per corner or one read request.
// ---------------------------------------------------------------------------
`default_nettype none
module tcd_front
  import tcd_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       hold,
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire logic                       in_kind,
  input  wire logic [NODE_W-1:0]          in_node_index,
  input  wire logic signed [OFS_W-1:0]    in_offset_x,
  input  wire logic signed [OFS_W-1:0]    in_offset_y,
  input  wire logic signed [OFS_W-1:0]    in_offset_z,
  input  wire logic signed [CHG_W-1:0]    in_charge,
  input  wire logic [SCALE_W-1:0]         charge_scale,
  input  wire logic [CELLS_W-1:0]         cells_x,
  input  wire logic [CELLS_W-1:0]         cells_y,
  input  wire logic                       q_full,
  output logic                            q_push,
  output op_t                             q_op
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_BASE = 3'd2;
  localparam logic [2:0] ST_AX   = 3'd3;
  localparam logic [2:0] ST_AY   = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  localparam int BASE_W = 46;
  localparam int AX_W   = 47;
  localparam int AY_W   = 48;

  logic [2:0]                state_r, state_nxt;
  logic [2:0]                k_r;
  logic [NODE_W-1:0]         node_r;
  logic signed [OFS_W-1:0]   x_r, y_r, z_r;
  logic signed [CHG_W-1:0]   q_r;
  logic signed [BASE_W-1:0]  base_r;
  logic signed [AX_W-1:0]    ax_r [2];
  logic signed [AY_W-1:0]    ay_r [4];
  logic [6:0]                row_r;
  logic [12:0]               plane_r;

  logic [OFS_W-1:0]          fx [2];
  logic [OFS_W-1:0]          fy [2];
  logic [OFS_W-1:0]          fz [2];
  logic signed [56:0]        prod_b;
  logic signed [63:0]        prod_x [2];
  logic signed [64:0]        prod_y [4];
  logic signed [65:0]        prod_w;
  logic signed [WGT_W-1:0]   weight;
  logic [ADDR_W-1:0]         corner;

  function automatic logic signed [OFS_W-1:0] clamp_ofs(input logic signed [OFS_W-1:0] v);
    logic signed [OFS_W-1:0] r;
    r = v;
    if (v < -17'sd32768) r = -17'sd32768;
    if (v > 17'sd32768)  r = 17'sd32768;
    return r;
  endfunction

  function automatic logic [OFS_W-1:0] factor(input logic signed [OFS_W-1:0] v,
                                              input logic plus);
    logic signed [OFS_W:0] s;
    s = plus ? (18'sd32768 + OFS_W'(v)) : (18'sd32768 - OFS_W'(v));
    return s[OFS_W-1:0];
  endfunction

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      fx[i] = factor(x_r, i[0]);
      fy[i] = factor(y_r, i[0]);
      fz[i] = factor(z_r, i[0]);
    end
    prod_b = $signed({1'b0, charge_scale}) * q_r;
    for (int i = 0; i < 2; i++) begin
      prod_x[i] = base_r * $signed({1'b0, fx[i]});
    end
    for (int i = 0; i < 4; i++) begin
      prod_y[i] = ax_r[i % 2] * $signed({1'b0, fy[i / 2]});
    end
    prod_w = ay_r[k_r[1:0]] * $signed({1'b0, fz[k_r[2]]});
    weight = WGT_W'((prod_w + 66'sd4194304) >>> 23);
    corner = ADDR_W'(node_r) + ADDR_W'(k_r[0])
           + (k_r[1] ? ADDR_W'(row_r) : '0)
           + (k_r[2] ? ADDR_W'(plane_r) : '0);
  end

  assign in_full = (state_r != ST_IDLE) || hold;

  always_comb begin
    q_push = 1'b0;
    q_op   = '0;
    if (state_r == ST_READ) begin
      q_push    = 1'b1;
      q_op.rd   = 1'b1;
      q_op.addr = ADDR_W'(node_r);
    end else if (state_r == ST_EMIT) begin
      q_push      = 1'b1;
      q_op.addr   = corner;
      q_op.weight = weight;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_push && !hold) state_nxt = in_kind ? ST_READ : ST_BASE;
      ST_READ: if (!q_full) state_nxt = ST_IDLE;
      ST_BASE: state_nxt = ST_AX;
      ST_AX:   state_nxt = ST_AY;
      ST_AY:   state_nxt = ST_EMIT;
      ST_EMIT: if (!q_full && k_r == 3'd7) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      node_r <= in_node_index;
      x_r    <= clamp_ofs(in_offset_x);
      y_r    <= clamp_ofs(in_offset_y);
      z_r    <= clamp_ofs(in_offset_z);
      q_r    <= in_charge;
    end
    if (state_r == ST_BASE) begin
      base_r  <= BASE_W'((prod_b + 57'sd1024) >>> 11);
      row_r   <= 7'(cells_x) + 7'd2;
      plane_r <= {6'd0, 7'(cells_x) + 7'd2} * {6'd0, 7'(cells_y) + 7'd2};
    end
    if (state_r == ST_AX) begin
      for (int i = 0; i < 2; i++) ax_r[i] <= AX_W'((prod_x[i] + 64'sd16384) >>> 15);
    end
    if (state_r == ST_AY) begin
      for (int i = 0; i < 4; i++) ay_r[i] <= AY_W'((prod_y[i] + 65'sd16384) >>> 15);
    end
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_EMIT && !q_full) k_r <= k_r + 3'd1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tcd_back.sv =====
// ---------------------------------------------------------------------------
// tcd_back
// Clears the node store after reset, then carries out queued requests as saturating
// read-modify-write updates or node reads, one a cycle unless a read waits on an unread result.
// ---------------------------------------------------------------------------
`default_nettype none
module tcd_back
  import tcd_pkg::*;
#(
  parameter int NODE_COUNT = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  output logic                          clearing,
  input  wire logic                     q_empty,
  input  wire op_t                      q_head,
  output logic                          q_pop,
  output logic                          out_empty,
  input  wire logic                     out_pop,
  output logic signed [SUM_W-1:0]       out_node_sum
);

  localparam int AW = $clog2(NODE_COUNT);

  logic                     clr_r;
  logic [AW-1:0]            clr_cnt_r;
  logic                     s_valid_r, s_rd_r, s_inr_r;
  logic [AW-1:0]            s_addr_r;
  logic signed [WGT_W-1:0]  s_w_r;
  logic                     fwd_hit_r;
  logic [SUM_W-1:0]         fwd_data_r;
  logic                     out_valid_r;
  logic signed [SUM_W-1:0]  out_sum_r;

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [SUM_W-1:0]         wr_data;
  logic [SUM_W-1:0]         rd_data;
  logic [AW-1:0]            rd_addr;
  logic                     issue_inr;
  logic signed [SUM_W-1:0]  old_sum;
  logic signed [SUM_W:0]    raw_sum;
  logic signed [SUM_W-1:0]  sat_sum;

  assign clearing  = clr_r;
  assign out_empty = !out_valid_r;
  assign out_node_sum = out_sum_r;

  assign q_pop = !clr_r && !q_empty
              && (!q_head.rd || (!out_valid_r && !(s_valid_r && s_rd_r)));
  assign rd_addr   = q_head.addr[AW-1:0];
  assign issue_inr = q_head.addr < ADDR_W'(NODE_COUNT);

  always_comb begin
    old_sum = fwd_hit_r ? fwd_data_r : rd_data;
    raw_sum = {old_sum[SUM_W-1], old_sum} + (SUM_W + 1)'(s_w_r);
    if (raw_sum[SUM_W] != raw_sum[SUM_W-1]) begin
      sat_sum = raw_sum[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
    end else begin
      sat_sum = raw_sum[SUM_W-1:0];
    end
    if (clr_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else begin
      wr_en   = s_valid_r && !s_rd_r && s_inr_r;
      wr_addr = s_addr_r;
      wr_data = sat_sum;
    end
  end

  tcd_ram #(
    .WIDTH (SUM_W),
    .DEPTH (NODE_COUNT)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (q_pop),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s_rd_r     <= q_head.rd;
      s_inr_r    <= issue_inr;
      s_addr_r   <= rd_addr;
      s_w_r      <= q_head.weight;
      fwd_hit_r  <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
    if (s_valid_r && s_rd_r) begin
      out_sum_r <= s_inr_r ? old_sum : '0;
    end
    if (!rst_n) begin
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(NODE_COUNT - 1)) clr_r <= 1'b0;
      end
      s_valid_r <= q_pop;
      if (s_valid_r && s_rd_r) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/trilinear_charge_deposit_core.sv =====
// ---------------------------------------------------------------------------
// trilinear_charge_deposit_core
// Cloud-in-cell charge deposit onto a 3-D node grid with node sum reads.
// ---------------------------------------------------------------------------
//  Channel   Handshake           Payload
//  in_       in_push / in_full   kind, node_index, offset_x/y/z, charge
//  out_      out_pop / out_empty node_sum
//  cfg_      cfg_we              cfg_index, cfg_wdata
//
// A deposit holds the input through acceptance, three multiply steps and
// eight emit steps that each queue one corner request; a full queue holds
// back the corner until there is room. The accumulator carries out one queued
// request a cycle, with a forwarded read-modify-write on the store, but a read
// waits while an earlier result is unread. A read holds the input through
// acceptance and its queue push; the request then passes the queue, the store
// read and the output register. After reset the store is cleared with in_full high.
// ---------------------------------------------------------------------------
`default_nettype none
module trilinear_charge_deposit_core
  import tcd_pkg::*;
#(
  parameter int NODE_COUNT = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_push,
  output logic                          in_full,
  input  wire logic                     in_kind,
  input  wire logic [NODE_W-1:0]        in_node_index,
  input  wire logic signed [OFS_W-1:0]  in_offset_x,
  input  wire logic signed [OFS_W-1:0]  in_offset_y,
  input  wire logic signed [OFS_W-1:0]  in_offset_z,
  input  wire logic signed [CHG_W-1:0]  in_charge,
  output logic                          out_empty,
  input  wire logic                     out_pop,
  output logic signed [SUM_W-1:0]       out_node_sum,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [SCALE_W-1:0]       cfg_wdata
);

  logic [SCALE_W-1:0] charge_scale_r;
  logic [CELLS_W-1:0] cells_x_r, cells_y_r;
  logic               clearing;
  logic               q_push, q_full, q_pop, q_empty;
  op_t                q_op, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      charge_scale_r <= 32'd65536;
      cells_x_r      <= 6'd30;
      cells_y_r      <= 6'd30;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHARGE_SCALE: charge_scale_r <= cfg_wdata;
        CFG_CELLS_X:      cells_x_r      <= cfg_wdata[CELLS_W-1:0];
        CFG_CELLS_Y:      cells_y_r      <= cfg_wdata[CELLS_W-1:0];
        default: ;
      endcase
    end
  end

  tcd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .hold          (clearing),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_kind       (in_kind),
    .in_node_index (in_node_index),
    .in_offset_x   (in_offset_x),
    .in_offset_y   (in_offset_y),
    .in_offset_z   (in_offset_z),
    .in_charge     (in_charge),
    .charge_scale  (charge_scale_r),
    .cells_x       (cells_x_r),
    .cells_y       (cells_y_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_op          (q_op)
  );

  tcd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_op),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head    (q_head)
  );

  tcd_back #(
    .NODE_COUNT (NODE_COUNT)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .clearing     (clearing),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_node_sum (out_node_sum)
  );

endmodule
`default_nettype wire
